// ===== sv/sfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SQ,
    ENG_SQRT,
    ENG_DIV
  } eng_state_t;

  typedef logic signed [16:0] raw_t;     // column sum, Q7.8 grown by one bit
  typedef logic signed [17:0] nrm_t;     // normal lane, Q1.16
  typedef logic signed [31:0] off_t;     // plane offset
  typedef logic signed [41:0] prod_t;    // normal lane times center lane

  localparam int NUM_PLANES = 6;
  localparam int DIV_W      = 50;        // rounded-division numerator width
  localparam int SQRT_STEPS = 32;
  localparam int CFG_ROWS   = 4;

  localparam nrm_t NRM_MAX = 18'sh1FFFF;
  localparam nrm_t NRM_MIN = 18'sh20000;
  localparam off_t OFF_MAX = 32'sh7FFFFFFF;
  localparam off_t OFF_MIN = 32'sh80000000;

  // right, left, bottom, top, far, near: which column joins column 4
  function automatic logic [1:0] plane_col(input logic [2:0] pl);
    plane_col = 2'(pl >> 1);
  endfunction

  function automatic logic plane_add(input logic [2:0] pl);
    plane_add = (pl == 3'd1) || (pl == 3'd2) || (pl == 3'd5);
  endfunction

endpackage
`default_nettype wire

// ===== sv/sphere_frustum_cull.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | signals                          | meaning
// s_      | in  | tvalid tready tdata[95:0]        | sphere center and radius
// m_      | out | tvalid tready tdata[7:0]         | visibility verdict
// cfg_    | in  | valid ready index[2:0] data[63:0]| matrix row write
//
// One sphere per cycle unless m_ stalls or planes are being rebuilt; a verdict
// passes registers v1 to v4 and m_tvalid after its beat is taken. Plane extraction
// after reset or a row write runs on one shared square-root unit and one
// bit-serial divider; s_tready is low while it runs. Reset starts that extraction.
// A stall on m_ freezes the whole pipeline; nothing is dropped or repeated.
module sphere_frustum_cull #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // center_x, center_y, center_z, radius, 1 pad bit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // visible, 7 pad bits
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // ---------------- configuration and plane extraction ----------------
  logic [63:0]            mrow [sfc_pkg::CFG_ROWS];
  sfc_pkg::nrm_t          nrm  [sfc_pkg::NUM_PLANES][3];
  sfc_pkg::off_t          off  [sfc_pkg::NUM_PLANES];

  sfc_pkg::eng_state_t    st, st_next;
  logic [2:0]             pl;
  logic [1:0]             dl;
  logic [5:0]             cnt;
  logic [33:0]            ssum;
  logic [34:0]            sq_rem;
  logic [31:0]            root;
  logic [33:0]            div_rem;
  logic [sfc_pkg::DIV_W-1:0] div_q;

  sfc_pkg::raw_t          a [4];
  logic [33:0]            sq_term, sq_add;
  logic [63:0]            xv;
  logic [34:0]            rs_sq, trial;
  logic                   sq_ge;
  logic                   a_neg;
  logic [16:0]            a_mag;
  logic [5:0]             sh;
  logic [sfc_pkg::DIV_W-1:0] num, div_q_step;
  logic [33:0]            rs_div, div_rem_step;
  logic                   div_ge;
  sfc_pkg::nrm_t          nsat;
  sfc_pkg::off_t          osat;
  logic                   cfg_hit, busy;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < 3'(sfc_pkg::CFG_ROWS));
  assign busy      = (st != sfc_pkg::ENG_IDLE);

  always_comb begin
    logic signed [15:0] w, o;
    for (int r = 0; r < 4; r++) begin
      w = mrow[r][63:48];
      o = mrow[r][16*sfc_pkg::plane_col(pl) +: 16];
      a[r] = sfc_pkg::plane_add(pl) ? (17'(w) + 17'(o)) : (17'(w) - 17'(o));
    end
  end

  assign sq_term = 34'(34'(a[cnt[1:0]]) * 34'(a[cnt[1:0]]));
  assign sq_add  = ssum + sq_term;

  // digit-by-digit square root, two radicand bits a step
  assign xv    = {ssum[33:0], 30'b0};
  assign rs_sq = {sq_rem[32:0], xv[{cnt[4:0], 1'b0} +: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign sq_ge = (rs_sq >= trial);

  // rounded division: (2|n| + L) / 2L, one quotient bit a step
  assign a_neg = a[dl][16];
  assign a_mag = a_neg ? 17'(-a[dl]) : 17'(a[dl]);
  assign sh    = (dl == 2'd3) ? 6'(FRAC_BITS + 15) : 6'd31;
  assign num   = ((sfc_pkg::DIV_W'(a_mag) << sh) << 1) + sfc_pkg::DIV_W'(root);
  assign rs_div       = {div_rem[32:0], div_q[sfc_pkg::DIV_W-1]};
  assign div_ge       = (rs_div >= {1'b0, root, 1'b0});
  assign div_rem_step = div_ge ? (rs_div - {1'b0, root, 1'b0}) : rs_div;
  assign div_q_step   = {div_q[sfc_pkg::DIV_W-2:0], div_ge};

  always_comb begin
    if (a_neg) begin
      nsat = (div_q_step > sfc_pkg::DIV_W'(131072)) ? sfc_pkg::NRM_MIN
                                                    : 18'(-div_q_step[17:0]);
      osat = (div_q_step > sfc_pkg::DIV_W'(64'h80000000)) ? sfc_pkg::OFF_MIN
                                                          : 32'(-div_q_step[31:0]);
    end else begin
      nsat = (div_q_step > sfc_pkg::DIV_W'(131071)) ? sfc_pkg::NRM_MAX
                                                    : div_q_step[17:0];
      osat = (div_q_step > sfc_pkg::DIV_W'(64'h7FFFFFFF)) ? sfc_pkg::OFF_MAX
                                                          : div_q_step[31:0];
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      sfc_pkg::ENG_IDLE: st_next = sfc_pkg::ENG_IDLE;
      sfc_pkg::ENG_SQ: begin
        if (cnt == 6'd2) begin
          if (sq_add != '0) st_next = sfc_pkg::ENG_SQRT;
          else if (pl == 3'd5) st_next = sfc_pkg::ENG_IDLE;
        end
      end
      sfc_pkg::ENG_SQRT: if (cnt == 6'd0) st_next = sfc_pkg::ENG_DIV;
      sfc_pkg::ENG_DIV: begin
        if (cnt == 6'(sfc_pkg::DIV_W) && dl == 2'd3)
          st_next = (pl == 3'd5) ? sfc_pkg::ENG_IDLE : sfc_pkg::ENG_SQ;
      end
      default: st_next = sfc_pkg::ENG_IDLE;
    endcase
    if (cfg_hit) st_next = sfc_pkg::ENG_SQ;
  end

  always_ff @(posedge clk) begin
    if (rst) st <= sfc_pkg::ENG_SQ;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mrow[0] <= 64'h0000_0000_0000_0100;
      mrow[1] <= 64'h0000_0000_0100_0000;
      mrow[2] <= 64'h0000_0100_0000_0000;
      mrow[3] <= 64'h0100_0000_0000_0000;
      pl <= '0;
      dl <= '0;
      cnt <= '0;
      ssum <= '0;
    end else if (cfg_hit) begin
      mrow[cfg_index[1:0]] <= cfg_data;
      pl <= '0;
      dl <= '0;
      cnt <= '0;
      ssum <= '0;
    end else begin
      case (st)
        sfc_pkg::ENG_SQ: begin
          if (cnt != 6'd2) begin
            ssum <= sq_add;
            cnt  <= cnt + 6'd1;
          end else if (sq_add == '0) begin
            for (int k = 0; k < 3; k++) nrm[pl][k] <= '0;
            off[pl] <= sfc_pkg::OFF_MAX;
            pl   <= (pl == 3'd5) ? 3'd0 : pl + 3'd1;
            cnt  <= '0;
            ssum <= '0;
          end else begin
            ssum   <= sq_add;
            cnt    <= 6'(sfc_pkg::SQRT_STEPS - 1);
            sq_rem <= '0;
            root   <= '0;
          end
        end
        sfc_pkg::ENG_SQRT: begin
          sq_rem <= sq_ge ? (rs_sq - trial) : rs_sq;
          root   <= {root[30:0], sq_ge};
          cnt    <= (cnt == 6'd0) ? 6'd0 : cnt - 6'd1;
          if (cnt == 6'd0) dl <= '0;
        end
        sfc_pkg::ENG_DIV: begin
          if (cnt == 6'd0) begin
            div_q   <= num;
            div_rem <= '0;
            cnt     <= 6'd1;
          end else if (cnt != 6'(sfc_pkg::DIV_W)) begin
            div_q   <= div_q_step;
            div_rem <= div_rem_step;
            cnt     <= cnt + 6'd1;
          end else begin
            cnt <= '0;
            if (dl == 2'd3) begin
              off[pl] <= osat;
              pl   <= (pl == 3'd5) ? 3'd0 : pl + 3'd1;
              ssum <= '0;
            end else begin
              nrm[pl][dl] <= nsat;
            end
            dl <= dl + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- sphere test pipeline ----------------
  logic adv;
  logic v1, v2, v3, v4;
  logic signed [23:0]     ctr [3];
  logic [22:0]            rad1, rad2;
  sfc_pkg::prod_t         prod [sfc_pkg::NUM_PLANES][3];
  logic signed [42:0]     s3 [sfc_pkg::NUM_PLANES];
  logic signed [50:0]     t3 [sfc_pkg::NUM_PLANES];
  logic [sfc_pkg::NUM_PLANES-1:0] cull4;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid && s_tready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] offr;
    if (adv) begin
      ctr[0] <= s_tdata[23:0];
      ctr[1] <= s_tdata[47:24];
      ctr[2] <= s_tdata[71:48];
      rad1   <= s_tdata[94:72];
      rad2   <= rad1;
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
        for (int k = 0; k < 3; k++) prod[p][k] <= 42'(nrm[p][k]) * 42'(ctr[k]);
        // dist + r*2^16 <= 0 means the plane culls
        offr  = 34'(off[p]) + $signed({11'b0, rad2});
        s3[p] <= 43'(prod[p][0]) + 43'(prod[p][1]);
        t3[p] <= 51'(prod[p][2]) + 51'($signed({offr, 16'b0}));
        cull4[p] <= ((52'(s3[p]) + 52'(t3[p])) <= 52'sd0);
      end
      m_tdata <= {7'b0, ~|cull4};
    end
  end

  // the stream is held off while planes are being rebuilt
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("input taken during plane extraction");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (st == sfc_pkg::ENG_SQ && pl == 3'd0 && cnt == 6'd0))
    else $error("row write did not restart extraction");

  a_idle_plane0: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (pl == 3'd0)) else $error("extraction stopped mid-sweep");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(v4) && $stable(v1)))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ===== verif/tb_sphere_frustum_cull.sv =====
`timescale 1ns / 1ps
module tb_sphere_frustum_cull;

  localparam logic [2:0] ROW1_IDX = 3'd0;
  localparam logic [2:0] ROW2_IDX = 3'd1;
  localparam logic [2:0] ROW3_IDX = 3'd2;
  localparam logic [2:0] ROW4_IDX = 3'd3;
  localparam logic [2:0] BAD_IDX  = 3'd6;
  localparam int FRAC = 8;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [22:0]        radius;
    logic signed [23:0] cz;
    logic signed [23:0] cy;
    logic signed [23:0] cx;
  } sphere_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  sphere_frustum_cull #(.FRAC_BITS(FRAC)) i_dut (.*);

  // local copy of the matrix and derived planes
  logic [63:0]    mat_rows [4];
  sfc_pkg::nrm_t  nrm [sfc_pkg::NUM_PLANES][3];
  sfc_pkg::off_t  offs [sfc_pkg::NUM_PLANES];

  sphere_t     sphere_q [$];
  logic        verdict_q [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req_cnt = 0;
  int          hold_seen_cnt = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint lane_val(logic [63:0] row, int c);
    logic signed [15:0] v;
    v = row[16*c +: 16];
    return longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint div_nearest(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = num < 0 ? longint'(-num) : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void extract_planes();
    longint a [4];
    longint unsigned s, len;
    longint v;
    int col;
    bit add;
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      col = p >> 1;
      add = (p == 1) || (p == 2) || (p == 5);
      for (int r = 0; r < 4; r++)
        a[r] = add ? lane_val(mat_rows[r], 3) + lane_val(mat_rows[r], col)
                   : lane_val(mat_rows[r], 3) - lane_val(mat_rows[r], col);
      s = 0;
      for (int r = 0; r < 3; r++) s = s + longint'(a[r] * a[r]);
      if (s == 0) begin
        for (int r = 0; r < 3; r++) nrm[p][r] = '0;
        offs[p] = sfc_pkg::OFF_MAX;
      end else begin
        len = int_sqrt(s << 30);
        for (int r = 0; r < 3; r++) begin
          v = div_nearest(a[r] * (64'sd1 <<< 31), len);
          v = v < -131072 ? -131072 : (v > 131071 ? 131071 : v);
          nrm[p][r] = sfc_pkg::nrm_t'(v);
        end
        v = div_nearest(a[3] * (64'sd1 <<< (FRAC + 15)), len);
        v = v < -64'sd2147483648 ? -64'sd2147483648
                                 : (v > 64'sd2147483647 ? 64'sd2147483647 : v);
        offs[p] = sfc_pkg::off_t'(v);
      end
    end
  endfunction

  function automatic logic sphere_visible(sphere_t sp);
    longint pdist, rad;
    logic vis;
    vis = 1'b1;
    rad = longint'({1'b0, sp.radius});
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      pdist = longint'(nrm[p][0]) * longint'(sp.cx) + longint'(nrm[p][1]) * longint'(sp.cy)
            + longint'(nrm[p][2]) * longint'(sp.cz) + longint'(offs[p]) * 65536;
      if (pdist <= -(rad * 65536)) vis = 1'b0;
    end
    return vis;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) verdict_q.push_back(sphere_visible(sphere_t'(s_tdata[94:0])));
      if (s_tvalid && !s_tready) begin
        // hold the beat
      end else if (sphere_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {1'b0, sphere_q.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic exp_vis;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0d", m_tdata[0]);
      end else begin
        exp_vis = verdict_q.pop_front();
        if (m_tdata[0] !== exp_vis || m_tdata[7:1] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("visible mismatch: expected %0d, got %0d (tdata %h)",
                     exp_vis, m_tdata[0], m_tdata);
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt = hold_req_cnt;
      hold_left = 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sampled away from the rising edge so queue and valid updates have settled
  task automatic drain();
    do @(negedge clk);
    while (sphere_q.size() > 0 || s_tvalid || verdict_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= ROW4_IDX) begin
      mat_rows[idx[1:0]] = val;
      extract_planes();
    end
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [63:0] r1, r2, r3, r4);
    drain();
    write_reg(ROW1_IDX, r1);
    write_reg(ROW2_IDX, r2);
    write_reg(ROW3_IDX, r3);
    write_reg(ROW4_IDX, r4);
  endtask

  function automatic sphere_t rand_sphere();
    sphere_t sp;
    int span;
    if ($urandom_range(3) == 0) begin
      sp = sphere_t'(95'({$urandom(), $urandom(), $urandom()}));
    end else begin
      // near the unit frustum scale so both verdicts show up
      span = 128 << $urandom_range(4);
      sp.cx = 24'($signed($urandom_range(2 * span)) - span);
      sp.cy = 24'($signed($urandom_range(2 * span)) - span);
      sp.cz = 24'($signed($urandom_range(2 * span)) - span);
      sp.radius = 23'($urandom_range(span));
    end
    return sp;
  endfunction

  function automatic logic [63:0] rand_row();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sphere_t mk(int x, int y, int z, int r);
    sphere_t sp;
    sp.cx = 24'(x); sp.cy = 24'(y); sp.cz = 24'(z); sp.radius = 23'(r);
    return sp;
  endfunction

  initial begin
    mat_rows[0] = 64'd256;
    mat_rows[1] = 64'd256 << 16;
    mat_rows[2] = 64'd256 << 32;
    mat_rows[3] = 64'd256 << 48;
    extract_planes();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset identity: unit cube frustum
    sphere_q.push_back(mk(0, 0, 0, 0));
    sphere_q.push_back(mk(512, 0, 0, 256));      // touches exactly: culled
    sphere_q.push_back(mk(512, 0, 0, 257));
    sphere_q.push_back(mk(0, -512, 0, 256));
    sphere_q.push_back(mk(0, 0, 768, 511));
    sphere_q.push_back(mk(0, 0, -768, 512));
    sphere_q.push_back(mk(8388607, 8388607, 8388607, 0));
    sphere_q.push_back(mk(-8388608, -8388608, -8388608, 0));
    sphere_q.push_back(mk(-8388608, 8388607, 0, 8388607));
    sphere_q.push_back(mk(8388607, 0, -8388608, 8388607));
    sphere_q.push_back(mk(256, 256, 256, 0));
    sphere_q.push_back(mk(257, 0, 0, 0));
    drain();

    // zero matrix: every normal has zero length, nothing culled
    load_matrix(64'd0, 64'd0, 64'd0, 64'd0);
    sphere_q.push_back(mk(8388607, -8388608, 0, 0));
    sphere_q.push_back(mk(-8388608, 8388607, 8388607, 8388607));
    // extreme lanes: saturated normals and offsets
    load_matrix({4{16'h7FFF}}, {4{16'h8000}}, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                {4{16'h7FFF}});
    sphere_q.push_back(mk(0, 0, 0, 0));
    sphere_q.push_back(mk(8388607, 8388607, -8388608, 8388607));
    load_matrix(64'd1, {16'h0001, 48'd0}, 64'd0, {16'h8000, 48'd0});
    sphere_q.push_back(mk(0, 0, 0, 0));
    sphere_q.push_back(mk(-8388608, 0, 0, 8388607));
    // out-of-range index must leave the matrix alone
    drain();
    write_reg(BAD_IDX, {4{16'h1234}});
    sphere_q.push_back(mk(100, -100, 50, 20));
    sphere_q.push_back(mk(0, 0, 0, 8388607));

    for (int ph = 0; ph < 4; ph++) begin
      for (int m = 0; m < 2; m++) begin
        drain();
        send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 45 : 15) : 0;
        recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 45 : 15) : 0;
        if (ph == 0 && m == 0)
          load_matrix(64'd256, 64'd256 << 16, 64'd256 << 32, 64'd256 << 48);
        else if (m == 0)
          load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
        else
          // perspective-like: scaled diagonal with w from z
          load_matrix({48'd0, 16'($urandom_range(64, 1024))},
                      {32'd0, 16'($urandom_range(64, 1024)), 16'd0},
                      {16'hFF00, 16'($urandom_range(64, 512)), 32'd0},
                      {16'd0, 16'($urandom_range(0, 255)) | 16'h8000, 32'd0});
        if (ph == 0 && m == 1) hold_req_cnt++;
        for (int k = 0; k < 170; k++) begin
          sphere_q.push_back(rand_sphere());
          if (ph == 1 && m == 0 && k == 85) drain();
        end
      end
    end

    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
